// ----- sv/bfiq_pkg.sv -----
`timescale 1ns / 1ps

package bfiq_pkg;

    // Store geometry. STORE_BITS must be a power of two, at least one word.
    localparam int STORE_BITS = 65536;
    localparam int KEY_BYTES  = 16;
    localparam int WORD_BITS  = 32;
    localparam int STORE_WORDS = STORE_BITS / WORD_BITS;
    localparam int ADDR_W     = $clog2(STORE_WORDS);
    localparam int MOD_W      = $clog2(STORE_BITS) + 1;
    localparam int SUM_W      = MOD_W + 2;

    // Field widths fixed by the interface.
    localparam int LEN_W      = 5;
    localparam int HCNT_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0]  CFG_HASH_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_ARRAY_BITS = 2'd1;
    localparam logic [HCNT_W-1:0]     HASH_COUNT_RST = 7'd7;
    localparam logic [CFG_DATA_W-1:0] ARRAY_BITS_RST = 17'd65536;

    // Command codes on the request port.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Hash constants.
    localparam logic [LEN_W-1:0] BLOCK_BYTES = 5'd16;
    localparam logic [31:0] HASH_SEED = 32'h97c29b3a;
    localparam logic [31:0] MUR_C1    = 32'h239b961b;
    localparam logic [31:0] MUR_C2    = 32'hab0e9789;
    localparam logic [31:0] MUR_C3    = 32'h38b34ae5;
    localparam logic [31:0] MUR_C4    = 32'ha1e38b93;
    localparam logic [31:0] FMIX_C1   = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2   = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [63:0]      key_low;
        logic [63:0]      key_high;
        logic [LEN_W-1:0] key_length;
    } req_t;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_KMUL1,
        HS_KMUL2,
        HS_KSTORE,
        HS_BODY,
        HS_TAIL,
        HS_MIX1,
        HS_MIX2,
        HS_F1,
        HS_F2,
        HS_F3,
        HS_FIN1,
        HS_FIN2,
        HS_DONE
    } hash_state_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_HASH,
        BK_MOD,
        BK_RD,
        BK_CHK,
        BK_SWEEP,
        BK_RESULT
    } back_state_t;

    // Rotate left by a small amount.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] t;
        t = {x, x} << r;
        return t[63:32];
    endfunction

    // Per-lane constants of the key mixing step.
    function automatic logic [31:0] lane_ca(input logic [1:0] j);
        logic [31:0] c;
        unique case (j)
            2'd0: c = MUR_C1;
            2'd1: c = MUR_C2;
            2'd2: c = MUR_C3;
            2'd3: c = MUR_C4;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] lane_cb(input logic [1:0] j);
        logic [31:0] c;
        unique case (j)
            2'd0: c = MUR_C2;
            2'd1: c = MUR_C3;
            2'd2: c = MUR_C4;
            2'd3: c = MUR_C1;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] lane_rk(input logic [1:0] j);
        logic [4:0] r;
        unique case (j)
            2'd0: r = 5'd15;
            2'd1: r = 5'd16;
            2'd2: r = 5'd17;
            2'd3: r = 5'd18;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] lane_rh(input logic [1:0] j);
        logic [4:0] r;
        unique case (j)
            2'd0: r = 5'd19;
            2'd1: r = 5'd17;
            2'd2: r = 5'd15;
            2'd3: r = 5'd13;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] lane_add(input logic [1:0] j);
        logic [31:0] c;
        unique case (j)
            2'd0: c = 32'h561ccd1b;
            2'd1: c = 32'h0bcaa747;
            2'd2: c = 32'h96cd1c35;
            2'd3: c = 32'h32ac3b17;
        endcase
        return c;
    endfunction

    // One step of a restoring remainder: shift in one dividend bit.
    function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
                                                 input logic b,
                                                 input logic [MOD_W-1:0] m);
        logic [MOD_W:0] s;
        s = {rem, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[MOD_W-1:0];
    endfunction

endpackage

// ----- sv/bfiq_front.sv -----
`timescale 1ns / 1ps

module bfiq_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  cmd,
    input  logic [63:0]                 key_low,
    input  logic [63:0]                 key_high,
    input  logic [bfiq_pkg::LEN_W-1:0]  key_length,
    input  logic                        init_busy,
    output logic                        req_valid,
    output bfiq_pkg::req_t              req,
    input  logic                        req_take
);
    import bfiq_pkg::*;

    req_t             q_reg [2];
    logic             wr_reg;
    logic             rd_reg;
    logic [1:0]       cnt_reg;
    logic             accept;
    req_t             cls;
    logic [LEN_W-1:0] len_eff;
    logic [127:0]     key_all;
    logic [127:0]     key_mask;

    // Classify the incoming request: decode the command, clamp the length,
    // and zero the key bytes beyond the length.
    always_comb
    begin
        unique case (cmd)
            CMD_INSERT: cls.op = OP_INSERT;
            CMD_QUERY:  cls.op = OP_QUERY;
            CMD_CLEAR:  cls.op = OP_CLEAR;
            default:    cls.op = OP_NOP;
        endcase
        if (key_length > LEN_W'(KEY_BYTES))
            len_eff = LEN_W'(KEY_BYTES);
        else
            len_eff = key_length;
        key_all = {key_high, key_low};
        for (int b = 0; b < 16; b++)
        begin
            if (LEN_W'(b) < len_eff)
                key_mask[8*b +: 8] = key_all[8*b +: 8];
            else
                key_mask[8*b +: 8] = 8'h00;
        end
        cls.key_low    = key_mask[63:0];
        cls.key_high   = key_mask[127:64];
        cls.key_length = len_eff;
    end

    assign full      = (cnt_reg == 2'd2) || init_busy;
    assign accept    = push && !full;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rd_reg];

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
                wr_reg <= !wr_reg;
            if (req_take)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, accept} - {1'b0, req_take};
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_reg] <= cls;
    end

endmodule

// ----- sv/bfiq_hash.sv -----
`timescale 1ns / 1ps

module bfiq_hash (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bfiq_pkg::req_t req,
    output logic           done,
    output logic [63:0]    h1,
    output logic [63:0]    h2
);
    import bfiq_pkg::*;

    hash_state_t state_reg;
    hash_state_t state_next;
    logic [1:0]       j_reg;
    logic [31:0]      tw_reg [4];
    logic [31:0]      kv_reg [4];
    logic [31:0]      hv_reg [4];
    logic [31:0]      prod_reg;
    logic [LEN_W-1:0] len_reg;
    logic             block_reg;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod_wide;
    logic [31:0]      body_x;
    logic [31:0]      body_new;
    logic [31:0]      mix_x [4];

    assign prod_wide = mul_a * mul_b;

    // Body step for the lane at position 0: xor, rotate, add neighbor, times five, add lane constant.
    assign body_x   = rotl32(hv_reg[0] ^ kv_reg[0], lane_rh(j_reg)) + hv_reg[1];
    assign body_new = body_x + (body_x << 2) + lane_add(j_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            mix_x[i] = hv_reg[i] ^ {{(32-LEN_W){1'b0}}, len_reg};
    end

    // Sequencer: next state and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        mul_a      = tw_reg[0];
        mul_b      = lane_ca(j_reg);
        done       = 1'b0;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (start)
                    state_next = HS_KMUL1;
            end
            HS_KMUL1:
                state_next = HS_KMUL2;
            HS_KMUL2:
            begin
                mul_a      = rotl32(prod_reg, lane_rk(j_reg));
                mul_b      = lane_cb(j_reg);
                state_next = HS_KSTORE;
            end
            HS_KSTORE:
            begin
                if (j_reg == 2'd3)
                    state_next = block_reg ? HS_BODY : HS_TAIL;
                else
                    state_next = HS_KMUL1;
            end
            HS_BODY:
            begin
                if (j_reg == 2'd3)
                    state_next = HS_MIX1;
            end
            HS_TAIL:
                state_next = HS_MIX1;
            HS_MIX1:
                state_next = HS_MIX2;
            HS_MIX2:
                state_next = HS_F1;
            HS_F1:
            begin
                mul_a      = hv_reg[0] ^ (hv_reg[0] >> 16);
                mul_b      = FMIX_C1;
                state_next = HS_F2;
            end
            HS_F2:
            begin
                mul_a      = prod_reg ^ (prod_reg >> 13);
                mul_b      = FMIX_C2;
                state_next = HS_F3;
            end
            HS_F3:
            begin
                if (j_reg == 2'd3)
                    state_next = HS_FIN1;
                else
                    state_next = HS_F1;
            end
            HS_FIN1:
                state_next = HS_FIN2;
            HS_FIN2:
                state_next = HS_DONE;
            HS_DONE:
            begin
                done       = 1'b1;
                state_next = HS_IDLE;
            end
            default:
                state_next = HS_IDLE;
        endcase
    end

    // State register and lane counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            j_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == HS_IDLE)
                j_reg <= 2'd0;
            else if (state_reg == HS_KSTORE || state_reg == HS_BODY || state_reg == HS_F3)
                j_reg <= j_reg + 2'd1;
        end
    end

    // Datapath. Lane words rotate through position 0 so each step works
    // on fixed places.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    tw_reg[0] <= req.key_low[31:0];
                    tw_reg[1] <= req.key_low[63:32];
                    tw_reg[2] <= req.key_high[31:0];
                    tw_reg[3] <= req.key_high[63:32];
                    for (int i = 0; i < 4; i++)
                        hv_reg[i] <= HASH_SEED;
                    len_reg   <= req.key_length;
                    block_reg <= (req.key_length == BLOCK_BYTES);
                end
            end
            HS_KMUL1, HS_KMUL2, HS_F1, HS_F2:
                prod_reg <= prod_wide[31:0];
            HS_KSTORE:
            begin
                kv_reg[0] <= kv_reg[1];
                kv_reg[1] <= kv_reg[2];
                kv_reg[2] <= kv_reg[3];
                kv_reg[3] <= prod_reg;
                tw_reg[0] <= tw_reg[1];
                tw_reg[1] <= tw_reg[2];
                tw_reg[2] <= tw_reg[3];
                tw_reg[3] <= tw_reg[0];
            end
            HS_BODY:
            begin
                hv_reg[0] <= hv_reg[1];
                hv_reg[1] <= hv_reg[2];
                hv_reg[2] <= hv_reg[3];
                hv_reg[3] <= body_new;
                kv_reg[0] <= kv_reg[1];
                kv_reg[1] <= kv_reg[2];
                kv_reg[2] <= kv_reg[3];
                kv_reg[3] <= kv_reg[0];
            end
            HS_TAIL:
            begin
                for (int i = 0; i < 4; i++)
                    hv_reg[i] <= hv_reg[i] ^ kv_reg[i];
            end
            HS_MIX1:
            begin
                hv_reg[0] <= mix_x[0] + mix_x[1] + mix_x[2] + mix_x[3];
                hv_reg[1] <= mix_x[1];
                hv_reg[2] <= mix_x[2];
                hv_reg[3] <= mix_x[3];
            end
            HS_MIX2, HS_FIN2:
            begin
                hv_reg[1] <= hv_reg[1] + hv_reg[0];
                hv_reg[2] <= hv_reg[2] + hv_reg[0];
                hv_reg[3] <= hv_reg[3] + hv_reg[0];
            end
            HS_F3:
            begin
                hv_reg[0] <= hv_reg[1];
                hv_reg[1] <= hv_reg[2];
                hv_reg[2] <= hv_reg[3];
                hv_reg[3] <= prod_reg ^ (prod_reg >> 16);
            end
            HS_FIN1:
                hv_reg[0] <= hv_reg[0] + hv_reg[1] + hv_reg[2] + hv_reg[3];
            default:
            begin
            end
        endcase
    end

    assign h1 = {hv_reg[1], hv_reg[0]};
    assign h2 = {hv_reg[3], hv_reg[2]};

endmodule

// ----- sv/bfiq_back.sv -----
`timescale 1ns / 1ps

module bfiq_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             req_valid,
    input  bfiq_pkg::req_t                   req,
    output logic                             req_take,
    output logic                             init_busy,
    output logic                             hash_start,
    input  logic                             hash_done,
    input  logic [63:0]                      hash_h1,
    input  logic [63:0]                      hash_h2,
    output logic                             empty,
    input  logic                             pop,
    output logic                             present,
    output logic [31:0]                      insert_count
);
    import bfiq_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic [HCNT_W-1:0]     hash_count_reg;
    logic [CFG_DATA_W-1:0] array_bits_reg;
    logic [31:0]           count_reg;
    logic [ADDR_W-1:0]     sweep_reg;
    logic [5:0]            mod_cnt_reg;

    op_t               op_reg;
    logic [MOD_W-1:0]  mod_reg;
    logic [MOD_W-1:0]  rem_a_reg;
    logic [MOD_W-1:0]  rem_b_reg;
    logic [MOD_W-1:0]  rem_w_reg;
    logic [63:0]       sh_a_reg;
    logic [63:0]       sh_b_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       step_reg;
    logic [HCNT_W-1:0] probe_reg;
    logic              present_reg;

    logic [31:0]       mem [STORE_WORDS];
    logic [31:0]       rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [31:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    logic              q_present_reg [2];
    logic [31:0]       q_count_reg [2];
    logic              q_wr_reg;
    logic              q_rd_reg;
    logic [1:0]        q_cnt_reg;
    logic              q_push;
    logic              pop_ok;

    logic [31:0]       ab_wide;
    logic [MOD_W-1:0]  mod_eff;
    logic [64:0]       acc_sum;
    logic [MOD_W-1:0]  adj;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  mod1;
    logic [SUM_W-1:0]  mod2;
    logic [SUM_W-1:0]  pos_red;
    logic [MOD_W-1:0]  pos_next;
    logic              hit;
    logic [HCNT_W-1:0] probe_inc;
    logic              probe_last;
    logic              res_present;
    logic [31:0]       res_count;

    assign cfg_ready = 1'b1;

    // Effective modulus: zero acts as one, oversize acts as the store size.
    assign ab_wide = 32'(array_bits_reg);
    always_comb
    begin
        if (ab_wide == 32'd0)
            mod_eff = MOD_W'(1);
        else if (ab_wide > 32'(STORE_BITS))
            mod_eff = MOD_W'(STORE_BITS);
        else
            mod_eff = MOD_W'(ab_wide);
    end

    // Next probe position, kept as a residue. A carry out of the 64-bit
    // sum removes 2^64, which shifts the residue by minus (2^64 mod m).
    assign acc_sum = {1'b0, acc_reg} + {1'b0, step_reg};
    assign adj     = (acc_sum[64] && rem_w_reg != '0) ? (mod_reg - rem_w_reg) : '0;
    assign pos_sum = SUM_W'(rem_a_reg) + SUM_W'(rem_b_reg) + SUM_W'(adj);
    assign mod1    = SUM_W'(mod_reg);
    assign mod2    = SUM_W'(mod_reg) << 1;
    always_comb
    begin
        if (pos_sum >= mod2)
            pos_red = pos_sum - mod2;
        else if (pos_sum >= mod1)
            pos_red = pos_sum - mod1;
        else
            pos_red = pos_sum;
    end
    assign pos_next = pos_red[MOD_W-1:0];

    assign hit        = rd_data_reg[rem_a_reg[4:0]];
    assign probe_inc  = probe_reg + 1'b1;
    assign probe_last = (probe_inc == hash_count_reg);

    // Result of the current request.
    assign res_present = (op_reg == OP_QUERY) && present_reg;
    assign res_count   = (op_reg == OP_INSERT) ? (count_reg + 32'd1) : count_reg;

    // Sequencer: next state, memory port and handshakes.
    always_comb
    begin
        state_next = state_reg;
        req_take   = 1'b0;
        hash_start = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = sweep_reg;
        mem_wd     = '0;
        mem_ra     = rem_a_reg[ADDR_W+4:5];
        q_push     = 1'b0;
        init_busy  = (state_reg == BK_INIT);
        unique case (state_reg)
            BK_INIT:
            begin
                mem_we = 1'b1;
                if (&sweep_reg)
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (req_valid)
                begin
                    req_take = 1'b1;
                    unique case (req.op)
                        OP_CLEAR: state_next = BK_SWEEP;
                        OP_NOP:   state_next = BK_RESULT;
                        OP_INSERT, OP_QUERY:
                        begin
                            hash_start = 1'b1;
                            state_next = BK_HASH;
                        end
                    endcase
                end
            end
            BK_HASH:
            begin
                if (hash_done)
                    state_next = BK_MOD;
            end
            BK_MOD:
            begin
                if (&mod_cnt_reg)
                    state_next = (hash_count_reg == '0) ? BK_RESULT : BK_RD;
            end
            BK_RD:
                state_next = BK_CHK;
            BK_CHK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    mem_we = 1'b1;
                    mem_wa = rem_a_reg[ADDR_W+4:5];
                    mem_wd = rd_data_reg | (32'd1 << rem_a_reg[4:0]);
                end
                if (((op_reg == OP_QUERY) && !hit) || probe_last)
                    state_next = BK_RESULT;
                else
                    state_next = BK_RD;
            end
            BK_SWEEP:
            begin
                mem_we = 1'b1;
                if (&sweep_reg)
                    state_next = BK_RESULT;
            end
            BK_RESULT:
            begin
                if (q_cnt_reg != 2'd2)
                begin
                    q_push     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    assign pop_ok = pop && (q_cnt_reg != 2'd0);

    // Control registers, configuration and result queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_INIT;
            hash_count_reg <= HASH_COUNT_RST;
            array_bits_reg <= ARRAY_BITS_RST;
            count_reg      <= 32'd0;
            sweep_reg      <= '0;
            mod_cnt_reg    <= 6'd0;
            q_wr_reg       <= 1'b0;
            q_rd_reg       <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HASH_COUNT)
                    hash_count_reg <= cfg_data[HCNT_W-1:0];
                else if (cfg_index == CFG_ARRAY_BITS)
                    array_bits_reg <= cfg_data;
            end
            if (state_reg == BK_INIT || state_reg == BK_SWEEP)
                sweep_reg <= sweep_reg + 1'b1;
            if (state_reg == BK_SWEEP)
                count_reg <= 32'd0;
            else if (q_push)
                count_reg <= res_count;
            if (state_reg == BK_MOD)
                mod_cnt_reg <= mod_cnt_reg + 6'd1;
            if (q_push)
                q_wr_reg <= !q_wr_reg;
            if (pop_ok)
                q_rd_reg <= !q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, pop_ok};
        end
    end

    // Request datapath: remainders, probe walk, presence flag.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (req_valid)
                begin
                    op_reg  <= req.op;
                    mod_reg <= mod_eff;
                end
            end
            BK_HASH:
            begin
                if (hash_done)
                begin
                    sh_a_reg    <= hash_h1;
                    sh_b_reg    <= hash_h2;
                    acc_reg     <= hash_h1;
                    step_reg    <= hash_h2;
                    rem_a_reg   <= '0;
                    rem_b_reg   <= '0;
                    rem_w_reg   <= (mod_reg == MOD_W'(1)) ? '0 : MOD_W'(1);
                    present_reg <= 1'b1;
                    probe_reg   <= '0;
                end
            end
            BK_MOD:
            begin
                rem_a_reg <= mod_step(rem_a_reg, sh_a_reg[63], mod_reg);
                rem_b_reg <= mod_step(rem_b_reg, sh_b_reg[63], mod_reg);
                rem_w_reg <= mod_step(rem_w_reg, 1'b0, mod_reg);
                sh_a_reg  <= sh_a_reg << 1;
                sh_b_reg  <= sh_b_reg << 1;
            end
            BK_CHK:
            begin
                probe_reg <= probe_inc;
                acc_reg   <= acc_sum[63:0];
                rem_a_reg <= pos_next;
                if ((op_reg == OP_QUERY) && !hit)
                    present_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Bit store, one word per address, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_present_reg[q_wr_reg] <= res_present;
            q_count_reg[q_wr_reg]   <= res_count;
        end
    end

    assign empty        = (q_cnt_reg == 2'd0);
    assign present      = q_present_reg[q_rd_reg];
    assign insert_count = q_count_reg[q_rd_reg];

    // The result queue never holds more than two entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'd2)
        else $error("result queue overfilled");

    // Only an insert writes the store during a probe.
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == BK_CHK) |-> (op_reg == OP_INSERT))
        else $error("store written by a non-insert probe");

    // A probe position is always inside the modulus.
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RD) |-> (rem_a_reg < mod_reg))
        else $error("probe position out of range");

    // Starting the hash moves the sequencer into the hash wait.
    a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
        hash_start |=> (state_reg == BK_HASH))
        else $error("hash started without waiting for it");

endmodule

// ----- sv/bloom_filter_insert_query.sv -----
`timescale 1ns / 1ps

// Bloom filter over a 65536-bit store with insert, query and clear requests.
// Keys of up to 16 bytes are hashed with MurmurHash3 x86_128 (seed 0x97c29b3a)
// and probe i tests or sets bit ((h1 + i*h2) mod 2^64) mod array_bits. A
// two-entry request queue in front and a two-entry result queue behind let
// both sides stall on their own. An insert or query runs the hash sequencer
// with its one shared 32x32 multiplier, then the bit-serial remainder unit
// that reduces h1, h2 and 2^64 by the modulus, then for each probe a read of
// the store and, for an insert, a write back with the bit set (a query stops
// at the first clear bit); the store has one read port and one write port.
// A clear sweeps the store one 32-bit word a cycle, all 2048 words. After
// reset the same clearing pass runs and full stays high; configuration
// writes are taken at any time.
module bloom_filter_insert_query (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfiq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       cmd,
    input  logic [63:0]                      key_low,
    input  logic [63:0]                      key_high,
    input  logic [bfiq_pkg::LEN_W-1:0]       key_length,
    output logic                             empty,
    input  logic                             pop,
    output logic                             present,
    output logic [31:0]                      insert_count
);
    import bfiq_pkg::*;

    req_t        req;
    logic        req_valid;
    logic        req_take;
    logic        init_busy;
    logic        hash_start;
    logic        hash_done;
    logic [63:0] hash_h1;
    logic [63:0] hash_h2;

    // Request intake and classification.
    bfiq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .key_low    (key_low),
        .key_high   (key_high),
        .key_length (key_length),
        .init_busy  (init_busy),
        .req_valid  (req_valid),
        .req        (req),
        .req_take   (req_take)
    );

    // Key hash sequencer.
    bfiq_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .req   (req),
        .done  (hash_done),
        .h1    (hash_h1),
        .h2    (hash_h2)
    );

    // Probe engine, bit store and result queue.
    bfiq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take),
        .init_busy    (init_busy),
        .hash_start   (hash_start),
        .hash_done    (hash_done),
        .hash_h1      (hash_h1),
        .hash_h2      (hash_h2),
        .empty        (empty),
        .pop          (pop),
        .present      (present),
        .insert_count (insert_count)
    );

endmodule
